>>> sv/dcbd_pkg.sv
// Shared constants and lookup functions for the decay correction unit.
package dcbd_pkg;

    localparam int HL_W        = 40;
    localparam int ACT_W       = 32;
    localparam int DAYS_OUT_W  = 21;
    localparam int RES_W       = 48;
    localparam int DATA_W      = 64;
    localparam int ADDR_W      = 4;
    localparam int EXP_FRAC    = 24;
    localparam int NTERMS      = 16;
    localparam int SIDE_W      = 1 + DAYS_OUT_W + ACT_W;

    localparam logic [0:0]            REG_HALF_LIFE = 1'b0;
    localparam logic [HL_W-1:0]       HL_RESET      = 40'd256;
    localparam logic [31:0]           LN2_Q32       = 32'hB17217F8;
    localparam logic [32:0]           ONE_Q32       = 33'h1_0000_0000;
    localparam logic [DAYS_OUT_W-1:0] DAYS_MAX      = 21'h1F_FFFF;
    localparam logic [RES_W-1:0]      ACT_MAX       = 48'hFFFF_FFFF_FFFF;

    // days of the year before the first of the given month (1..12)
    function automatic logic [8:0] months_before(input logic [3:0] mo);
        logic [8:0] v;
        case (mo)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // floor(2^32 / k) for the series divisors
    function automatic logic [32:0] recip(input int k);
        logic [32:0] v;
        case (k)
            1:       v = 33'h1_0000_0000;
            2:       v = 33'h0_8000_0000;
            3:       v = 33'h0_5555_5555;
            4:       v = 33'h0_4000_0000;
            5:       v = 33'h0_3333_3333;
            6:       v = 33'h0_2AAA_AAAA;
            7:       v = 33'h0_2492_4924;
            8:       v = 33'h0_2000_0000;
            9:       v = 33'h0_1C71_C71C;
            10:      v = 33'h0_1999_9999;
            11:      v = 33'h0_1745_D174;
            12:      v = 33'h0_1555_5555;
            13:      v = 33'h0_13B1_3B13;
            14:      v = 33'h0_1249_2492;
            15:      v = 33'h0_1111_1111;
            16:      v = 33'h0_1000_0000;
            default: v = 33'h1_0000_0000;
        endcase
        return v;
    endfunction

endpackage

>>> sv/dcbd_fifo.sv
// Small register FIFO used between the front, the back and the result port.
module dcbd_fifo #(
    parameter int W  = 8,
    parameter int AW = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_empty
);
    localparam int DEPTH = 1 << AW;

    logic [W-1:0] r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [AW:0]   r_cnt, n_cnt;
    logic          push_ok, pop_ok;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign push_ok = i_push & ~o_full;
    assign pop_ok  = i_pop & ~o_empty;

    always_comb begin
        n_wp  = push_ok ? r_wp + 1'b1 : r_wp;
        n_rp  = pop_ok ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (AW+1)'(push_ok) - (AW+1)'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

>>> sv/dcbd_front.sv
// Front end: takes an item, maps both dates to day ordinals and flags order.
module dcbd_front #(
    parameter int YEAR_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [4:0]            i_ref_day,
    input  logic [3:0]            i_ref_month,
    input  logic [YEAR_BITS-1:0]  i_ref_year,
    input  logic [4:0]            i_meas_day,
    input  logic [3:0]            i_meas_month,
    input  logic [YEAR_BITS-1:0]  i_meas_year,
    input  logic [31:0]           i_ref_activity,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output logic [YEAR_BITS+9+dcbd_pkg::ACT_W:0] o_q_data
);
    localparam int OW = YEAR_BITS + 9;

    logic          r_v, n_v;
    logic [OW-1:0] r_ord_ref, r_ord_meas;
    logic [31:0]   r_act;
    logic          take;
    logic [OW:0]   diff;
    logic          err;
    logic [OW-1:0] days;

    // ordinal plus one, so that a day of zero stays non-negative
    function automatic logic [OW-1:0] ordinal(input logic [4:0] d, input logic [3:0] m,
                                               input logic [YEAR_BITS-1:0] y);
        logic [3:0]    mo;
        logic [OW-1:0] o;
        mo = (m == 4'd0) ? 4'd1 : ((m > 4'd12) ? 4'd12 : m);
        o  = OW'(y) * OW'(365) + OW'((OW'(y) + OW'(3)) >> 2)
           + OW'(dcbd_pkg::months_before(mo)) + OW'(d);
        if (y[1:0] == 2'b00 && mo > 4'd2) begin
            o = o + OW'(1);
        end
        return o;
    endfunction

    assign o_full   = r_v & i_q_full;
    assign take     = i_push & ~o_full;
    assign o_q_push = r_v & ~i_q_full;
    assign diff     = {1'b0, r_ord_meas} - {1'b0, r_ord_ref};
    assign err      = diff[OW];
    assign days     = err ? '0 : diff[OW-1:0];
    assign o_q_data = {err, days, r_act};

    always_comb begin
        n_v = r_v;
        if (take) begin
            n_v = 1'b1;
        end else if (o_q_push) begin
            n_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ord_ref  <= ordinal(i_ref_day, i_ref_month, i_ref_year);
            r_ord_meas <= ordinal(i_meas_day, i_meas_month, i_meas_year);
            r_act      <= i_ref_activity;
        end
    end

endmodule

>>> sv/dcbd_back.sv
// Back end: pipelined divide by half-life, 2^-f series, scaling and saturation.
module dcbd_back #(
    parameter int YEAR_BITS = 12,
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [dcbd_pkg::HL_W-1:0]         i_half_life,
    input  logic                              i_q_empty,
    output logic                              o_q_pop,
    input  logic [YEAR_BITS+9+dcbd_pkg::ACT_W:0] i_q_data,
    input  logic                              i_out_full,
    output logic                              o_out_push,
    output logic [dcbd_pkg::DAYS_OUT_W-1:0]   o_elapsed_days,
    output logic [dcbd_pkg::RES_W-1:0]        o_decayed_activity,
    output logic                              o_date_order_error
);
    localparam int OW = YEAR_BITS + 9;
    localparam int NW = OW + 32;
    localparam int NB = NW - dcbd_pkg::EXP_FRAC;
    localparam int EW = (OW > dcbd_pkg::DAYS_OUT_W) ? OW : dcbd_pkg::DAYS_OUT_W;
    localparam int SW = dcbd_pkg::SIDE_W;
    localparam int CW = 1 + 6 + SW;
    localparam int K  = dcbd_pkg::NTERMS;

    logic        en;
    logic [39:0] hl;
    logic        r_p_v, r_r_v;

    // stall the whole pipe only when a finished item cannot leave
    assign en         = ~(r_r_v & i_out_full);
    assign o_q_pop    = en & ~i_q_empty;
    assign o_out_push = r_r_v & ~i_out_full;
    assign hl         = (i_half_life == '0) ? 40'd1 : i_half_life;

    // ---------------- divider: one quotient bit per stage
    logic          r_dv_v    [0:NW];
    logic [39:0]   r_dv_rem  [0:NW];
    logic [NW-1:0] r_dv_q    [0:NW];
    logic [OW-1:0] r_dv_days [0:NW];
    logic [SW-1:0] r_dv_side [0:NW];

    logic [OW-1:0] in_days;
    logic [EW-1:0] days_ext;
    logic [dcbd_pkg::DAYS_OUT_W-1:0] in_ed;

    assign in_days  = i_q_data[dcbd_pkg::ACT_W +: OW];
    assign days_ext = EW'(in_days);
    assign in_ed    = (days_ext > EW'(dcbd_pkg::DAYS_MAX)) ? dcbd_pkg::DAYS_MAX
                                                            : days_ext[dcbd_pkg::DAYS_OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= o_q_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_rem[0]  <= '0;
            r_dv_q[0]    <= '0;
            r_dv_days[0] <= in_days;
            r_dv_side[0] <= {i_q_data[OW+dcbd_pkg::ACT_W], in_ed,
                             i_q_data[dcbd_pkg::ACT_W-1:0]};
        end
    end

    for (genvar i = 0; i < NW; i++) begin : g_div
        localparam int P = NW - 1 - i;
        logic        nb;
        logic [40:0] trial, sub;
        logic        ge;

        if (P >= 32) begin : g_bit
            assign nb = r_dv_days[i][P-32];
        end else begin : g_zero
            assign nb = 1'b0;
        end

        assign trial = {r_dv_rem[i], nb};
        assign ge    = (trial >= {1'b0, hl});
        assign sub   = trial - {1'b0, hl};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[i+1] <= 1'b0;
            end else if (en) begin
                r_dv_v[i+1] <= r_dv_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_rem[i+1]  <= ge ? sub[39:0] : trial[39:0];
                r_dv_q[i+1]    <= {r_dv_q[i][NW-2:0], ge};
                r_dv_days[i+1] <= r_dv_days[i];
                r_dv_side[i+1] <= r_dv_side[i];
            end
        end
    end

    // ---------------- series stages; level 0 holds y = f * ln2
    logic          r_c_v   [0:K];
    logic [32:0]   r_c_t   [0:K];
    logic [32:0]   r_c_sum [0:K];
    logic [31:0]   r_c_y   [0:K];
    logic [CW-1:0] r_c_cw  [0:K];

    logic [NB-1:0] qn;
    logic [23:0]   qf;
    logic [55:0]   fy;
    logic          qzero;

    assign qn    = r_dv_q[NW][NW-1:dcbd_pkg::EXP_FRAC];
    assign qf    = r_dv_q[NW][dcbd_pkg::EXP_FRAC-1:0];
    assign fy    = 56'(qf) * 56'(dcbd_pkg::LN2_Q32);
    assign qzero = (qn >= NB'(32 + FRAC_BITS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v[0] <= 1'b0;
        end else if (en) begin
            r_c_v[0] <= r_dv_v[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_t[0]   <= dcbd_pkg::ONE_Q32;
            r_c_sum[0] <= dcbd_pkg::ONE_Q32;
            r_c_y[0]   <= fy[55:24];
            r_c_cw[0]  <= {qzero, qn[5:0], r_dv_side[NW]};
        end
    end

    for (genvar k = 1; k <= K; k++) begin : g_term
        logic          r_a_v, r_b_v;
        logic [31:0]   r_a_p, r_b_p, r_b_q0;
        logic [32:0]   r_a_sum, r_b_sum;
        logic [31:0]   r_a_y, r_b_y;
        logic [CW-1:0] r_a_cw, r_b_cw;
        logic [64:0]   ty, pr;
        logic [36:0]   qk, rem;
        logic [32:0]   tk;

        assign ty  = 65'(r_c_t[k-1]) * 65'(r_c_y[k-1]);
        assign pr  = 65'(r_a_p) * 65'(dcbd_pkg::recip(k));
        assign qk  = 37'(r_b_q0) * 37'(k);
        assign rem = 37'(r_b_p) - qk;
        // reciprocal estimate is at most one short
        assign tk  = (rem >= 37'(k)) ? 33'(r_b_q0) + 33'd1 : 33'(r_b_q0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_v    <= 1'b0;
                r_b_v    <= 1'b0;
                r_c_v[k] <= 1'b0;
            end else if (en) begin
                r_a_v    <= r_c_v[k-1];
                r_b_v    <= r_a_v;
                r_c_v[k] <= r_b_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_a_p    <= ty[63:32];
                r_a_sum  <= r_c_sum[k-1];
                r_a_y    <= r_c_y[k-1];
                r_a_cw   <= r_c_cw[k-1];
                r_b_p    <= r_a_p;
                r_b_q0   <= pr[63:32];
                r_b_sum  <= r_a_sum;
                r_b_y    <= r_a_y;
                r_b_cw   <= r_a_cw;
                r_c_t[k] <= tk;
                r_c_sum[k] <= ((k % 2) == 1) ? r_b_sum - tk : r_b_sum + tk;
                r_c_y[k]   <= r_b_y;
                r_c_cw[k]  <= r_b_cw;
            end
        end
    end

    // ---------------- scale and saturate
    logic [63:0]   r_p_prod;
    logic [CW-1:0] r_p_cw;
    logic [64:0]   am;
    logic [6:0]    sh;
    logic [63:0]   shifted;
    logic [dcbd_pkg::RES_W-1:0] res;
    logic [dcbd_pkg::RES_W-1:0] r_r_res;
    logic [dcbd_pkg::DAYS_OUT_W-1:0] r_r_ed;
    logic          r_r_err;

    assign am      = 65'(r_c_cw[K][dcbd_pkg::ACT_W-1:0]) * 65'(r_c_sum[K]);
    assign sh      = 7'(32 - FRAC_BITS) + 7'(r_p_cw[SW +: 6]);
    assign shifted = r_p_prod >> sh;
    assign res     = r_p_cw[CW-1] ? '0
                   : ((shifted > 64'(dcbd_pkg::ACT_MAX)) ? dcbd_pkg::ACT_MAX
                                                         : shifted[dcbd_pkg::RES_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_r_v <= 1'b0;
        end else if (en) begin
            r_p_v <= r_c_v[K];
            r_r_v <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_prod <= am[63:0];
            r_p_cw   <= r_c_cw[K];
            r_r_res  <= res;
            r_r_ed   <= r_p_cw[dcbd_pkg::ACT_W +: dcbd_pkg::DAYS_OUT_W];
            r_r_err  <= r_p_cw[SW-1];
        end
    end

    assign o_elapsed_days     = r_r_ed;
    assign o_decayed_activity = r_r_res;
    assign o_date_order_error = r_r_err;

endmodule

>>> sv/decay_correction_by_dates_unit.sv
// Throughput: one item per cycle; the bit-per-stage divider and the three-stage
// series terms are fully pipelined, so the pipe only halts while the result queue is full.
// Reset (synchronous, active low) empties all queues and stages and sets the half-life
// register to one day (256); no clearing pass is needed.
module decay_correction_by_dates_unit #(
    parameter int FRAC_BITS = 16,
    parameter int YEAR_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [4:0]                          i_ref_day,
    input  logic [3:0]                          i_ref_month,
    input  logic [YEAR_BITS-1:0]                i_ref_year,
    input  logic [4:0]                          i_meas_day,
    input  logic [3:0]                          i_meas_month,
    input  logic [YEAR_BITS-1:0]                i_meas_year,
    input  logic [31:0]                         i_ref_activity,
    output logic                                empty,
    input  logic                                pop,
    output logic [dcbd_pkg::DAYS_OUT_W-1:0]     o_elapsed_days,
    output logic [dcbd_pkg::RES_W-1:0]          o_decayed_activity,
    output logic                                o_date_order_error,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dcbd_pkg::ADDR_W-1:0]         paddr,
    input  logic [dcbd_pkg::DATA_W-1:0]         pwdata,
    output logic [dcbd_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    localparam int QW = YEAR_BITS + 9 + dcbd_pkg::ACT_W + 1;
    localparam int RW = dcbd_pkg::DAYS_OUT_W + dcbd_pkg::RES_W + 1;

    logic [dcbd_pkg::HL_W-1:0] r_half_life;
    logic          cfg_wr;
    logic          sel_hl;

    logic          mq_push, mq_full, mq_pop, mq_empty;
    logic [QW-1:0] mq_wdata, mq_rdata;

    logic          oq_push, oq_full;
    logic [RW-1:0] oq_wdata, oq_rdata;
    logic [dcbd_pkg::DAYS_OUT_W-1:0] b_ed;
    logic [dcbd_pkg::RES_W-1:0]      b_res;
    logic          b_err;

    assign pready = 1'b1;
    assign sel_hl = (paddr[3] == dcbd_pkg::REG_HALF_LIFE);
    assign cfg_wr = psel & penable & pwrite & pready & sel_hl;
    assign prdata = sel_hl ? dcbd_pkg::DATA_W'(r_half_life) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_life <= dcbd_pkg::HL_RESET;
        end else if (cfg_wr) begin
            r_half_life <= pwdata[dcbd_pkg::HL_W-1:0];
        end
    end

    dcbd_front #(.YEAR_BITS(YEAR_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_ref_day      (i_ref_day),
        .i_ref_month    (i_ref_month),
        .i_ref_year     (i_ref_year),
        .i_meas_day     (i_meas_day),
        .i_meas_month   (i_meas_month),
        .i_meas_year    (i_meas_year),
        .i_ref_activity (i_ref_activity),
        .i_q_full       (mq_full),
        .o_q_push       (mq_push),
        .o_q_data       (mq_wdata)
    );

    dcbd_fifo #(.W(QW), .AW(2)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mq_push),
        .i_wdata (mq_wdata),
        .o_full  (mq_full),
        .i_pop   (mq_pop),
        .o_rdata (mq_rdata),
        .o_empty (mq_empty)
    );

    dcbd_back #(.YEAR_BITS(YEAR_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_half_life        (r_half_life),
        .i_q_empty          (mq_empty),
        .o_q_pop            (mq_pop),
        .i_q_data           (mq_rdata),
        .i_out_full         (oq_full),
        .o_out_push         (oq_push),
        .o_elapsed_days     (b_ed),
        .o_decayed_activity (b_res),
        .o_date_order_error (b_err)
    );

    assign oq_wdata = {b_err, b_ed, b_res};

    dcbd_fifo #(.W(RW), .AW(1)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_wdata (oq_wdata),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_rdata (oq_rdata),
        .o_empty (empty)
    );

    assign o_decayed_activity = oq_rdata[dcbd_pkg::RES_W-1:0];
    assign o_elapsed_days     = oq_rdata[dcbd_pkg::RES_W +: dcbd_pkg::DAYS_OUT_W];
    assign o_date_order_error = oq_rdata[RW-1];

endmodule

>>> bench/testbench.sv
// Self-checking bench for the decay correction unit: queued driver, monitor, scoreboard.
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY   = 108;
    localparam int STALL_MAX = 20000;

    typedef struct packed {
        logic [4:0]  ref_day;
        logic [3:0]  ref_month;
        logic [11:0] ref_year;
        logic [4:0]  meas_day;
        logic [3:0]  meas_month;
        logic [11:0] meas_year;
        logic [31:0] ref_activity;
    } t_dates;

    typedef struct packed {
        logic [dcbd_pkg::DAYS_OUT_W-1:0] days;
        logic [dcbd_pkg::RES_W-1:0]      activity;
        logic                            order_err;
    } t_decay;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty, pready;
    logic [4:0]  i_ref_day = '0, i_meas_day = '0;
    logic [3:0]  i_ref_month = '0, i_meas_month = '0;
    logic [11:0] i_ref_year = '0, i_meas_year = '0;
    logic [31:0] i_ref_activity = '0;
    logic [dcbd_pkg::DAYS_OUT_W-1:0] o_elapsed_days;
    logic [dcbd_pkg::RES_W-1:0]      o_decayed_activity;
    logic                            o_date_order_error;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [dcbd_pkg::ADDR_W-1:0] paddr = '0;
    logic [dcbd_pkg::DATA_W-1:0] pwdata = '0;
    logic [dcbd_pkg::DATA_W-1:0] prdata;

    decay_correction_by_dates_unit u_top (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_dates pending_dates[$];
    t_decay due_results[$];
    logic [dcbd_pkg::HL_W-1:0] half_life = dcbd_pkg::HL_RESET;
    int send_idle = 0, take_idle = 0;
    bit hold_off = 1'b0;
    int errors = 0, checked = 0, idle_cycles = 0;

    function automatic logic [63:0] day_number(logic [4:0] d, logic [3:0] mo, logic [11:0] y);
        logic [3:0] mc;
        logic [63:0] n;
        mc = (mo < 1) ? 4'd1 : (mo > 12) ? 4'd12 : mo;
        n = 365 * 64'(y) + (64'(y) + 3) / 4 + 64'(dcbd_pkg::months_before(mc)) + 64'(d) - 1;
        if (y[1:0] == 2'b00 && mc > 2) n += 1;
        return n;
    endfunction

    function automatic t_decay decay_at(t_dates it, logic [dcbd_pkg::HL_W-1:0] hl);
        logic [63:0] a, b, days, q, n, y, t, m, hld, shift;
        logic [127:0] prod;
        t_decay r;
        a = day_number(it.ref_day, it.ref_month, it.ref_year);
        b = day_number(it.meas_day, it.meas_month, it.meas_year);
        r.order_err = (b < a);
        days = r.order_err ? 64'd0 : b - a;
        hld = (hl == 0) ? 64'd1 : 64'(hl);
        q = (days << 32) / hld;
        n = q >> dcbd_pkg::EXP_FRAC;
        y = ((q & 64'hFF_FFFF) * 64'(dcbd_pkg::LN2_Q32)) >> dcbd_pkg::EXP_FRAC;
        t = 64'(dcbd_pkg::ONE_Q32);
        m = t;
        for (int k = 1; k <= dcbd_pkg::NTERMS; k++) begin
            t = ((t * y) >> 32) / k;
            if (k % 2) m -= t; else m += t;
        end
        prod = 128'(it.ref_activity) * 128'(m);
        shift = 16 + n;
        prod = (shift >= 64) ? 128'd0 : 128'(prod[63:0] >> shift);
        r.activity = (prod > 128'(dcbd_pkg::ACT_MAX)) ? dcbd_pkg::ACT_MAX
                                                     : prod[dcbd_pkg::RES_W-1:0];
        r.days = (days > 64'(dcbd_pkg::DAYS_MAX)) ? dcbd_pkg::DAYS_MAX
                                                  : days[dcbd_pkg::DAYS_OUT_W-1:0];
        return r;
    endfunction

    function automatic t_dates random_dates();
        t_dates it;
        it.ref_day = 5'($urandom_range(1, 31));
        it.ref_month = 4'($urandom_range(1, 12));
        it.ref_year = 12'($urandom);
        it.meas_day = 5'($urandom_range(1, 31));
        it.meas_month = 4'($urandom_range(1, 12));
        // mostly forward and near, sometimes anything, sometimes malformed
        case ($urandom_range(0, 9))
            0, 1: it.meas_year = 12'($urandom);
            2: begin
                it.meas_year = it.ref_year;
                it.meas_day = 5'($urandom);
                it.meas_month = 4'($urandom);
                it.ref_day = 5'($urandom);
                it.ref_month = 4'($urandom);
            end
            default: it.meas_year = 12'(it.ref_year + $urandom_range(0, 3));
        endcase
        it.ref_activity = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1000) : $urandom;
        return it;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (push && !full) begin
            due_results.push_back(decay_at(pending_dates.pop_front(), half_life));
        end
        if (!i_rst_n || (push && full)) begin
        end else if (pending_dates.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
            push <= 1'b1;
            {i_ref_day, i_ref_month, i_ref_year, i_meas_day, i_meas_month, i_meas_year,
             i_ref_activity} <= pending_dates[0];
        end else begin
            push <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_decay exp_r;
        if (pop && !empty) begin
            if (due_results.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                exp_r = due_results.pop_front();
                checked++;
                if (o_elapsed_days !== exp_r.days) begin
                    $error("elapsed_days exp %0d got %0d", exp_r.days, o_elapsed_days);
                    errors++;
                end
                if (o_decayed_activity !== exp_r.activity) begin
                    $error("decayed_activity exp %0h got %0h", exp_r.activity,
                           o_decayed_activity);
                    errors++;
                end
                if (o_date_order_error !== exp_r.order_err) begin
                    $error("date_order_error exp %0b got %0b", exp_r.order_err,
                           o_date_order_error);
                    errors++;
                end
            end
        end
        pop <= i_rst_n && !hold_off && ($urandom_range(0, 99) >= take_idle);
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_half_life(logic [dcbd_pkg::HL_W-1:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= dcbd_pkg::ADDR_W'(8 * dcbd_pkg::REG_HALF_LIFE);
        pwdata <= dcbd_pkg::DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        half_life = v;
    endtask

    task automatic drain();
        while (pending_dates.size() > 0 || due_results.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic add_dates(logic [4:0] rd, logic [3:0] rm, logic [11:0] ry,
                             logic [4:0] md, logic [3:0] mm, logic [11:0] my,
                             logic [31:0] act);
        pending_dates.push_back({rd, rm, ry, md, mm, my, act});
    endtask

    initial begin
        logic [dcbd_pkg::HL_W-1:0] settings[6];
        settings = '{40'd256, 40'd0, 40'hFF_FFFF_FFFF, 40'd1, 40'd7680, 40'd1};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, reversed order, malformed dates, leap years
        send_idle = 10; take_idle = 65;
        add_dates(1, 1, 0, 1, 1, 0, 32'hFFFF_FFFF);
        add_dates(1, 1, 0, 31, 15, 4095, 32'hFFFF_FFFF);
        add_dates(31, 12, 4095, 1, 1, 0, 32'd12345);
        add_dates(28, 2, 2000, 1, 3, 2000, 32'd1000);
        add_dates(28, 2, 2001, 1, 3, 2001, 32'd1000);
        add_dates(0, 0, 1999, 31, 2, 1999, 32'd5);
        add_dates(31, 15, 7, 0, 13, 8, 32'd0);
        add_dates(5, 6, 100, 5, 6, 100, 32'd1);
        add_dates(1, 1, 2047, 2, 1, 2047, 32'h8000_0000);
        add_dates(1, 1, 0, 1, 1, 4095, 32'h7FFF_FFFF);
        add_dates(10, 10, 1000, 11, 10, 1000, 32'hFFFF_FFFF);
        drain();
        write_half_life(40'd0);
        add_dates(1, 1, 0, 1, 1, 0, 32'hFFFF_FFFF);
        add_dates(1, 1, 0, 2, 1, 0, 32'hFFFF_FFFF);
        add_dates(1, 1, 0, 31, 15, 4095, 32'hFFFF_FFFF);
        drain();

        // random phases over several half-lives, the extremes included
        for (int p = 0; p < 6; p++) begin
            if (p == 3) begin
                send_idle = 65; take_idle = 10;
            end else if (p == 5) begin
                send_idle = 0; take_idle = 0;
            end
            write_half_life((p == 1) ? {$urandom, 8'($urandom_range(0, 255))}
                                     : settings[p]);
            for (int i = 0; i < 115; i++) pending_dates.push_back(random_dates());
            if (p == 4) begin
                // hold the receiver off long enough to back the pipe up to the input
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            drain();
        end

        $display("Checked %0d results under the reset half-life and seven written ones,",
                 checked);
        $display("with both-side stalls and a long receiver hold-off.");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
